[hdl/ehyst_pkg.sv]
package ehyst_pkg;

  // Pixel classes kept in the line stores and the window.
  typedef enum logic [1:0] {
    CLS_BLACK  = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } cls_t;

  localparam int CFG_W       = 11;   // width of the size registers and position counters
  localparam int PIX_W       = 8;
  localparam int WIN_SIZE    = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [PIX_W-1:0] PIX_BLACK  = 8'd0;
  localparam logic [PIX_W-1:0] PIX_STRONG = 8'd255;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] ROW_SAT      = 11'h7FF;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Control that travels with a request from the read cycle to the
  // write-back cycle.
  typedef struct packed {
    cls_t cls;
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } s1_ctl_t;

endpackage

[hdl/edge_hysteresis_3x3.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_tvalid/in_tready  | in_tdata: pixel_value; in_tuser: is_pad
// out_    | output    | out_tvalid/out_tready| out_tdata: edge_on; out_tlast: last_of_frame
// cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// One request per clock is sustained while the output queue has room. A request
// reads the line store in the cycle it is accepted and writes it back in the next
// cycle, so the memory port sets the pace; a write and a read of the same column in
// adjacent cycles (image width of one) are forwarded.
// A result passes the write-back stage and the output queue before it appears on the output.
// Reset is synchronous, active low; the line stores are not cleared.
// A four-entry output queue lets the input keep running while results wait.
module edge_hysteresis_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel_value
  input  logic                          in_tuser,   // [0] is_pad
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] edge_on, [7:1] zero
  output logic                          out_tlast,  // last_of_frame
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ehyst_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ehyst_pkg::CFG_W;

  // Frame size registers.
  logic [CW-1:0] width_r, height_r;
  logic [CW-1:0] cfg_clamped_w, cfg_clamped_h;

  // Position counters: input side counts requests, output side counts results.
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [CW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [CW-1:0] out_row_r, out_row_nxt;

  // Accept stage.
  logic                 skip0;
  logic                 take0;
  ehyst_pkg::cls_t      cls0;
  logic                 emit0;
  logic                 last0;
  logic [AW-1:0]        addr0;
  logic [CW:0]          in_col_inc, out_col_inc, out_row_inc;
  ehyst_pkg::s1_ctl_t   ctl0;

  // Write-back stage.
  logic                 s1_valid_r;
  ehyst_pkg::s1_ctl_t   s1_ctl_r;
  logic [AW-1:0]        s1_addr_r;

  // Line store: [3:2] upper line class, [1:0] middle line class.
  logic [3:0]           lines_mem [MAX_WIDTH];
  logic [3:0]           rd_q_r;
  logic                 fwd_r;
  logic [3:0]           fwd_q_r;
  logic [3:0]           rd_data;
  logic [3:0]           wr_data;
  ehyst_pkg::cls_t      top1, mid1;

  // 3x3 window of classes, indexed [column][row], column 0 oldest.
  ehyst_pkg::cls_t      win_r   [ehyst_pkg::WIN_SIZE][ehyst_pkg::WIN_SIZE];
  ehyst_pkg::cls_t      win_nxt [ehyst_pkg::WIN_SIZE][ehyst_pkg::WIN_SIZE];
  logic                 strong_near;
  logic                 edge1;

  // Output queue.
  logic [1:0]                      fifo_r [ehyst_pkg::FIFO_DEPTH];
  logic [ehyst_pkg::FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ehyst_pkg::FIFO_CW-1:0]   count_r;
  logic                            push, pop;

  // ------------------------------------------------------------------
  // Configuration: zero reads as one, anything above the maximum as the maximum.
  // ------------------------------------------------------------------
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped_w = CW'(1);
      cfg_clamped_h = CW'(1);
    end else begin
      cfg_clamped_w = (int'(cfg_wdata) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : cfg_wdata;
      cfg_clamped_h = (int'(cfg_wdata) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : cfg_wdata;
    end
  end

  // ------------------------------------------------------------------
  // Accept stage: classify, pick the line store column and update positions.
  // ------------------------------------------------------------------
  assign in_tready = ({1'b0, count_r} + (ehyst_pkg::FIFO_CW+1)'(s1_valid_r))
                     < (ehyst_pkg::FIFO_CW+1)'(ehyst_pkg::FIFO_DEPTH);

  // A pad that arrives before any pixel of a frame is dropped.
  assign skip0 = in_tuser && (in_col_r == '0) && (in_row_r == '0);
  assign take0 = in_tvalid && in_tready && !skip0;

  always_comb begin
    if (in_tuser || (in_row_r >= height_r)) begin
      cls0 = ehyst_pkg::CLS_BLACK;
    end else if (in_tdata == ehyst_pkg::PIX_BLACK) begin
      cls0 = ehyst_pkg::CLS_BLACK;
    end else if (in_tdata == ehyst_pkg::PIX_STRONG) begin
      cls0 = ehyst_pkg::CLS_STRONG;
    end else begin
      cls0 = ehyst_pkg::CLS_WEAK;
    end
  end

  assign addr0       = AW'(in_col_r);
  assign emit0       = (in_row_r >= CW'(2)) || ((in_row_r == CW'(1)) && (in_col_r != '0));
  assign in_col_inc  = {1'b0, in_col_r} + (CW+1)'(1);
  assign out_col_inc = {1'b0, out_col_r} + (CW+1)'(1);
  assign out_row_inc = {1'b0, out_row_r} + (CW+1)'(1);
  assign last0       = (out_row_inc >= {1'b0, height_r}) && (out_col_inc >= {1'b0, width_r});

  always_comb begin
    ctl0.cls    = cls0;
    ctl0.emit   = emit0;
    ctl0.left   = (out_col_r == '0);
    ctl0.right  = (out_col_inc >= {1'b0, width_r});
    ctl0.top    = (out_row_r == '0);
    ctl0.bottom = (out_row_inc >= {1'b0, height_r});
    ctl0.last   = last0;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take0) begin
      if (in_col_inc >= {1'b0, width_r}) begin
        in_col_nxt = '0;
        if (in_row_r != ehyst_pkg::ROW_SAT) begin
          in_row_nxt = in_row_r + CW'(1);
        end
      end else begin
        in_col_nxt = in_col_inc[CW-1:0];
      end
      if (emit0) begin
        if (out_col_inc >= {1'b0, width_r}) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc[CW-1:0];
        end else begin
          out_col_nxt = out_col_inc[CW-1:0];
        end
        // The last result of a frame restarts every position counter.
        if (last0) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= ehyst_pkg::RESET_WIDTH;
      height_r   <= ehyst_pkg::RESET_HEIGHT;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= take0;
      if (take0) begin
        fwd_r <= s1_valid_r && (s1_addr_r == addr0);
      end
      if (cfg_we) begin
        // A size write restarts the frame.
        if (cfg_index == ehyst_pkg::REG_IMAGE_WIDTH) begin
          width_r <= cfg_clamped_w;
        end else begin
          height_r <= cfg_clamped_h;
        end
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
    end
  end

  // ------------------------------------------------------------------
  // Line store: read on accept, write back in the next cycle.
  // ------------------------------------------------------------------
  assign rd_data = fwd_r ? fwd_q_r : rd_q_r;
  assign top1    = ehyst_pkg::cls_t'(rd_data[3:2]);
  assign mid1    = ehyst_pkg::cls_t'(rd_data[1:0]);
  assign wr_data = {mid1, s1_ctl_r.cls};

  always_ff @(posedge clk) begin
    if (take0) begin
      rd_q_r    <= lines_mem[addr0];
      fwd_q_r   <= wr_data;
      s1_addr_r <= addr0;
      s1_ctl_r  <= ctl0;
    end
    if (s1_valid_r) begin
      lines_mem[s1_addr_r] <= wr_data;
    end
  end

  // ------------------------------------------------------------------
  // Window shift and hysteresis decision.
  // ------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < ehyst_pkg::WIN_SIZE - 1; k++) begin
      for (int r = 0; r < ehyst_pkg::WIN_SIZE; r++) begin
        win_nxt[k][r] = win_r[k+1][r];
      end
    end
    win_nxt[ehyst_pkg::WIN_SIZE-1][0] = top1;
    win_nxt[ehyst_pkg::WIN_SIZE-1][1] = mid1;
    win_nxt[ehyst_pkg::WIN_SIZE-1][2] = s1_ctl_r.cls;
  end

  // Neighbors beyond the image border are masked off.
  always_comb begin
    strong_near = 1'b0;
    for (int k = 0; k < ehyst_pkg::WIN_SIZE; k++) begin
      for (int r = 0; r < ehyst_pkg::WIN_SIZE; r++) begin
        if (!((k == 0) && s1_ctl_r.left) && !((k == 2) && s1_ctl_r.right) &&
            !((r == 0) && s1_ctl_r.top) && !((r == 2) && s1_ctl_r.bottom) &&
            (win_nxt[k][r] == ehyst_pkg::CLS_STRONG)) begin
          strong_near = 1'b1;
        end
      end
    end
  end

  assign edge1 = (win_nxt[1][1] == ehyst_pkg::CLS_STRONG) ||
                 ((win_nxt[1][1] == ehyst_pkg::CLS_WEAK) && strong_near);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ehyst_pkg::WIN_SIZE; k++) begin
        for (int r = 0; r < ehyst_pkg::WIN_SIZE; r++) begin
          win_r[k][r] <= ehyst_pkg::CLS_BLACK;
        end
      end
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Output queue.
  // ------------------------------------------------------------------
  assign push = s1_valid_r && s1_ctl_r.emit;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= {s1_ctl_r.last, edge1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ehyst_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ehyst_pkg::FIFO_AW'(1);
      end
      count_r <= count_r + ehyst_pkg::FIFO_CW'(push) - ehyst_pkg::FIFO_CW'(pop);
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {7'd0, fifo_r[rd_ptr_r][0]};
  assign out_tlast  = fifo_r[rd_ptr_r][1];

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ehyst_pkg::FIFO_CW'(ehyst_pkg::FIFO_DEPTH))
    else $error("output queue over capacity");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r != ehyst_pkg::FIFO_CW'(ehyst_pkg::FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_r) |-> $past(s1_valid_r))
    else $error("forwarding without a preceding write-back");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0))
    else $error("size write did not restart the frame");

endmodule
